[design/c3as_pkg.sv]
// Shared types and constants of the 3x3 convolution block.
// Used by the row multiply-add unit and the top level; depends on nothing.
package c3as_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int COEF_ROW_W = 3 * COEF_W;
  localparam int PROD_W     = COEF_W + PIX_W + 1;
  localparam int ROW_SUM_W  = PROD_W + 2;
  localparam int TOTAL_W    = ROW_SUM_W + 2;
  localparam int ROW_OUT_W  = 12;
  localparam int COL_OUT_W  = 11;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_ROW_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

  typedef logic [PIX_W-1:0]             pix_t;
  typedef logic [COEF_ROW_W-1:0]        coef_row_t;
  typedef logic signed [ROW_SUM_W-1:0]  row_sum_t;

endpackage

[design/conv3x3_abs_saturate_core.sv]
// Streaming 3x3 convolution with absolute value and clamp to 255, one pixel per cycle
// unless the output is held off or the line stores are being cleared. A result passes
// through stage 1, stage 2 and the output register. The rate is bounded by the single read
// and write per cycle of each line-store RAM. After reset the line stores are cleared
// with in_ready low; configuration writes are taken during that sweep.
// Depends on c3as_pkg, c3as_ram and c3as_row_mac.
module conv3x3_abs_saturate_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  c3as_pkg::pix_t                    in_pixel,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [c3as_pkg::PIX_W-1:0]        out_value,
  output logic [c3as_pkg::ROW_OUT_W-1:0]    out_center_row,
  output logic [c3as_pkg::COL_OUT_W-1:0]    out_center_col,
  output logic                              out_valid_res,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [c3as_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [c3as_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef struct packed {
    logic                           valid;
    logic                           inner;
    logic                           last;
    logic [c3as_pkg::ROW_OUT_W-1:0] row;
    logic [c3as_pkg::COL_OUT_W-1:0] col;
  } tag_t;

  // Configuration registers.
  c3as_pkg::coef_row_t              coef_top_r, coef_mid_r, coef_bot_r;
  logic [c3as_pkg::WIDTH_W-1:0]     width_r;
  logic [c3as_pkg::HEIGHT_W-1:0]    height_r;

  // Line-store clearing sweep.
  logic                             clr_busy_r;
  logic [CW-1:0]                    clr_addr_r;

  // Raster position of the next pixel.
  logic [CW-1:0]                    col_r, col_nxt;
  logic [RW-1:0]                    row_r, row_nxt;

  // Stage 1: accepted pixel waiting for its line-store data.
  logic                             s1_v_r;
  c3as_pkg::pix_t                   s1_px_r;
  logic [CW-1:0]                    s1_col_r;
  tag_t                             s1_tag_r;
  logic                             fwd_r;
  c3as_pkg::pix_t                   fwd_a_r, fwd_b_r;

  // Stage 2: row sums.
  logic                             s2_v_r;
  tag_t                             s2_tag_r;
  c3as_pkg::row_sum_t               s2_top_r, s2_mid_r, s2_bot_r;

  // Output register.
  logic                             out_valid_r;
  c3as_pkg::pix_t                   out_value_r;
  tag_t                             out_tag_r;

  c3as_pkg::pix_t                   win_r [6];

  logic [WW-1:0]                    w_eff;
  logic [HW-1:0]                    h_eff;
  logic [CW-1:0]                    c_cur;
  logic [RW-1:0]                    r_cur;
  tag_t                             tag_cur;
  logic                             in_fire, out_en, s2_take, s1_take, s1_move, s2_move;
  logic                             col_wrap;
  c3as_pkg::pix_t                   ram_a_q, ram_b_q, mid_c, top_c;
  logic                             ram_we;
  logic [CW-1:0]                    ram_waddr;
  c3as_pkg::pix_t                   ram_a_wdata, ram_b_wdata;
  c3as_pkg::row_sum_t               sum_top, sum_mid, sum_bot;
  logic signed [c3as_pkg::TOTAL_W-1:0] total;
  logic [c3as_pkg::TOTAL_W-1:0]     mag;
  c3as_pkg::pix_t                   clamped;

  // ---------------------------------------------------------------- control
  assign out_en    = !out_valid_r || out_ready;
  assign s2_take   = !s2_v_r || out_en;
  assign s1_take   = !s1_v_r || s2_take;
  assign s1_move   = s1_v_r && s2_take;
  assign s2_move   = s2_v_r && out_en;
  assign in_ready  = s1_take && !clr_busy_r;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r <= '0;
      coef_mid_r <= '0;
      coef_bot_r <= '0;
      width_r    <= c3as_pkg::WIDTH_W'(2048);
      height_r   <= c3as_pkg::HEIGHT_W'(4096);
    end else if (cfg_valid) begin
      case (cfg_index)
        c3as_pkg::REG_COEFF_TOP:    coef_top_r <= cfg_data;
        c3as_pkg::REG_COEFF_MID:    coef_mid_r <= cfg_data;
        c3as_pkg::REG_COEFF_BOT:    coef_bot_r <= cfg_data;
        c3as_pkg::REG_IMAGE_WIDTH:  width_r    <= cfg_data[c3as_pkg::WIDTH_W-1:0];
        c3as_pkg::REG_IMAGE_HEIGHT: height_r   <= cfg_data[c3as_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------- position counting
  // Zero or oversized geometry falls back to the maximum.
  assign w_eff = (width_r == '0 || 32'(width_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_r);
  assign h_eff = (height_r == '0 || 32'(height_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                                                                 : HW'(height_r);

  always_comb begin
    if (in_frame_start) begin
      c_cur = '0;
      r_cur = '0;
    end else begin
      c_cur = (WW'(col_r) >= w_eff) ? '0 : col_r;
      r_cur = (HW'(row_r) >= h_eff) ? '0 : row_r;
    end
    tag_cur.valid = (r_cur != '0) && (c_cur != '0);
    tag_cur.inner = (r_cur > RW'(1)) && (c_cur > CW'(1));
    tag_cur.last  = tag_cur.valid && (HW'(r_cur) == h_eff - 1'b1)
                    && (WW'(c_cur) == w_eff - 1'b1);
    tag_cur.row   = tag_cur.valid ? c3as_pkg::ROW_OUT_W'(r_cur - 1'b1) : '0;
    tag_cur.col   = tag_cur.valid ? c3as_pkg::COL_OUT_W'(c_cur - 1'b1) : '0;

    col_wrap = (WW'(c_cur) + 1'b1) >= w_eff;
    col_nxt  = col_wrap ? '0 : c_cur + 1'b1;
    if (!col_wrap) begin
      row_nxt = r_cur;
    end else if ((HW'(r_cur) + 1'b1) >= h_eff) begin
      row_nxt = '0;
    end else begin
      row_nxt = r_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ------------------------------------------------------------- line stores
  // The pixel leaving stage 1 writes its column; the clearing sweep owns the port first.
  assign ram_we      = clr_busy_r || s1_move;
  assign ram_waddr   = clr_busy_r ? clr_addr_r : s1_col_r;
  assign ram_a_wdata = clr_busy_r ? '0 : s1_px_r;
  assign ram_b_wdata = clr_busy_r ? '0 : mid_c;

  c3as_ram #(.WIDTH(c3as_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_a_wdata),
    .re    (in_fire),
    .raddr (c_cur),
    .rdata (ram_a_q)
  );

  c3as_ram #(.WIDTH(c3as_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_b_wdata),
    .re    (in_fire),
    .raddr (c_cur),
    .rdata (ram_b_q)
  );

  // When the previous pixel wrote the same column in the cycle this one read it,
  // the RAM returned stale data, so the written values are taken directly.
  assign mid_c = fwd_r ? fwd_a_r : ram_a_q;
  assign top_c = fwd_r ? fwd_b_r : ram_b_q;

  // ------------------------------------------------------------------ stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r  <= in_pixel;
      s1_col_r <= c_cur;
      s1_tag_r <= tag_cur;
      fwd_a_r  <= s1_px_r;
      fwd_b_r  <= mid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_fire) begin
      fwd_r <= s1_move && (s1_col_r == c_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_move) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top_c;
      win_r[2] <= win_r[3];
      win_r[3] <= mid_c;
      win_r[4] <= win_r[5];
      win_r[5] <= s1_px_r;
    end
  end

  c3as_row_mac u_mac_top (
    .coef_row  (coef_top_r),
    .left_px   (win_r[0]),
    .center_px (win_r[1]),
    .right_px  (top_c),
    .row_sum   (sum_top)
  );

  c3as_row_mac u_mac_mid (
    .coef_row  (coef_mid_r),
    .left_px   (win_r[2]),
    .center_px (win_r[3]),
    .right_px  (mid_c),
    .row_sum   (sum_mid)
  );

  c3as_row_mac u_mac_bot (
    .coef_row  (coef_bot_r),
    .left_px   (win_r[4]),
    .center_px (win_r[5]),
    .right_px  (s1_px_r),
    .row_sum   (sum_bot)
  );

  // ------------------------------------------------------------------ stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_move) begin
      s2_v_r <= 1'b1;
    end else if (s2_move) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_tag_r <= s1_tag_r;
      s2_top_r <= sum_top;
      s2_mid_r <= sum_mid;
      s2_bot_r <= sum_bot;
    end
  end

  assign total = c3as_pkg::TOTAL_W'(s2_top_r) + c3as_pkg::TOTAL_W'(s2_mid_r)
               + c3as_pkg::TOTAL_W'(s2_bot_r);
  assign mag     = total[c3as_pkg::TOTAL_W-1] ? $unsigned(-total) : $unsigned(total);
  assign clamped = (mag > c3as_pkg::TOTAL_W'(255)) ? 8'hFF : mag[c3as_pkg::PIX_W-1:0];

  // ----------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_tag_r   <= s2_tag_r;
      out_value_r <= s2_tag_r.inner ? clamped : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_center_row = out_tag_r.row;
  assign out_center_col = out_tag_r.col;
  assign out_valid_res  = out_tag_r.valid;
  assign out_last       = out_tag_r.last;

`ifndef SYNTH
  // No pixel may enter while the line stores are still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_fire)
    else $error("input transfer during line-store clearing");

  // A result without a center carries only zeros.
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_value == '0 && out_center_row == '0
                                       && out_center_col == '0 && !out_last))
    else $error("nonzero result for a missing center");

  // Forwarding only happens when stage 1 holds a pixel.
  a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && fwd_r) |-> s1_v_r)
    else $error("line-store forwarding without a pixel in stage 1");

  // A pixel leaving stage 1 always lands in stage 2 on the next cycle.
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> s2_v_r)
    else $error("stage 2 lost a pixel from stage 1");
`endif

endmodule

[design/c3as_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written in the same cycle returns the old contents.
module c3as_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/c3as_row_mac.sv]
// One neighborhood row: three signed coefficients times three unsigned pixels, summed.
// Depends on c3as_pkg for the pixel, coefficient row and row sum types.
module c3as_row_mac (
  input  c3as_pkg::coef_row_t coef_row,
  input  c3as_pkg::pix_t      left_px,
  input  c3as_pkg::pix_t      center_px,
  input  c3as_pkg::pix_t      right_px,
  output c3as_pkg::row_sum_t  row_sum
);

  logic signed [c3as_pkg::PROD_W-1:0] prod_l;
  logic signed [c3as_pkg::PROD_W-1:0] prod_c;
  logic signed [c3as_pkg::PROD_W-1:0] prod_r;

  // Pixels get a zero sign bit so the products are fully signed.
  assign prod_l = $signed(coef_row[7:0])   * $signed({1'b0, left_px});
  assign prod_c = $signed(coef_row[15:8])  * $signed({1'b0, center_px});
  assign prod_r = $signed(coef_row[23:16]) * $signed({1'b0, right_px});

  assign row_sum = c3as_pkg::ROW_SUM_W'(prod_l) + c3as_pkg::ROW_SUM_W'(prod_c)
                 + c3as_pkg::ROW_SUM_W'(prod_r);

endmodule

[tb/sv/conv3x3_result_checker.sv]
// Result checker for conv3x3_abs_saturate_core: mirrors the line stores, the window and
// the position counters, predicts one result per pixel transfer and compares in order.
// Depends on c3as_pkg.
module conv3x3_result_checker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  c3as_pkg::pix_t                  in_pixel,
  input  logic                            in_frame_start,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [c3as_pkg::PIX_W-1:0]      out_value,
  input  logic [c3as_pkg::ROW_OUT_W-1:0]  out_center_row,
  input  logic [c3as_pkg::COL_OUT_W-1:0]  out_center_col,
  input  logic                            out_valid_res,
  input  logic                            out_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [c3as_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [c3as_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              results_due
);

  localparam int PIXEL_MAX    = 255;
  localparam int REPORT_LIMIT = 10;
  localparam int RESET_WIDTH  = 2048;
  localparam int RESET_HEIGHT = 4096;

  typedef struct packed {
    logic [c3as_pkg::PIX_W-1:0]     value;
    logic [c3as_pkg::ROW_OUT_W-1:0] center_row;
    logic [c3as_pkg::COL_OUT_W-1:0] center_col;
    logic                           valid_res;
    logic                           last;
  } center_result_t;

  c3as_pkg::coef_row_t             coef_top;
  c3as_pkg::coef_row_t             coef_mid;
  c3as_pkg::coef_row_t             coef_bot;
  logic [c3as_pkg::WIDTH_W-1:0]    width_reg;
  logic [c3as_pkg::HEIGHT_W-1:0]   height_reg;
  c3as_pkg::pix_t                  line_above [MAX_WIDTH];
  c3as_pkg::pix_t                  line_two_above [MAX_WIDTH];
  // Two previous columns of the top, middle and bottom lines, oldest first.
  c3as_pkg::pix_t                  window [6];
  int                              next_col;
  int                              next_row;
  int                              reported;
  center_result_t                  predicted_centers [$];

  function automatic int row_dot(c3as_pkg::coef_row_t k, c3as_pkg::pix_t left,
                                 c3as_pkg::pix_t mid, c3as_pkg::pix_t right);
    return int'($signed(k[0 +: c3as_pkg::COEF_W])) * int'(left)
         + int'($signed(k[c3as_pkg::COEF_W +: c3as_pkg::COEF_W])) * int'(mid)
         + int'($signed(k[2*c3as_pkg::COEF_W +: c3as_pkg::COEF_W])) * int'(right);
  endfunction

  task automatic convolve_pixel(input c3as_pkg::pix_t px, input logic fs,
                                output center_result_t res);
    int             w;
    int             h;
    int             c;
    int             r;
    int             total;
    c3as_pkg::pix_t top_px;
    c3as_pkg::pix_t mid_px;
    w = (width_reg == 0 || width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg == 0 || height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    c = fs ? 0 : next_col;
    r = fs ? 0 : next_row;
    // A geometry that shrank since the last pixel wraps the position at once.
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    top_px = line_two_above[c];
    mid_px = line_above[c];
    res = '0;
    if (r >= 2 && c >= 2) begin
      total = row_dot(coef_top, window[0], window[1], top_px)
            + row_dot(coef_mid, window[2], window[3], mid_px)
            + row_dot(coef_bot, window[4], window[5], px);
      if (total < 0) total = -total;
      res.value = (total > PIXEL_MAX) ? c3as_pkg::PIX_W'(PIXEL_MAX)
                                      : c3as_pkg::PIX_W'(total);
    end
    if (r >= 1 && c >= 1) begin
      res.center_row = c3as_pkg::ROW_OUT_W'(r - 1);
      res.center_col = c3as_pkg::COL_OUT_W'(c - 1);
      res.valid_res  = 1'b1;
      res.last       = (r == h - 1) && (c == w - 1);
    end
    window[0] = window[1];
    window[1] = top_px;
    window[2] = window[3];
    window[3] = mid_px;
    window[4] = window[5];
    window[5] = px;
    line_two_above[c] = mid_px;
    line_above[c]     = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  always @(posedge clk) begin : track
    center_result_t want;
    center_result_t got;
    if (!rst_n) begin
      coef_top   = '0;
      coef_mid   = '0;
      coef_bot   = '0;
      width_reg  = c3as_pkg::WIDTH_W'(RESET_WIDTH);
      height_reg = c3as_pkg::HEIGHT_W'(RESET_HEIGHT);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_above[i]     = '0;
        line_two_above[i] = '0;
      end
      for (int i = 0; i < 6; i++) window[i] = '0;
      next_col   = 0;
      next_row   = 0;
      reported   = 0;
      mismatches = 0;
      predicted_centers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          c3as_pkg::REG_COEFF_TOP:    coef_top   = cfg_data;
          c3as_pkg::REG_COEFF_MID:    coef_mid   = cfg_data;
          c3as_pkg::REG_COEFF_BOT:    coef_bot   = cfg_data;
          c3as_pkg::REG_IMAGE_WIDTH:  width_reg  = cfg_data[c3as_pkg::WIDTH_W-1:0];
          c3as_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data[c3as_pkg::HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        convolve_pixel(in_pixel, in_frame_start, want);
        predicted_centers.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {out_value, out_center_row, out_center_col, out_valid_res, out_last};
        if (predicted_centers.size() == 0) begin
          mismatches++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("ERROR: result transfer with no pixel pending: value=%0d row=%0d col=%0d",
                     got.value, got.center_row, got.center_col);
          end
        end else begin
          want = predicted_centers.pop_front();
          if (got.value !== want.value || got.center_row !== want.center_row ||
              got.center_col !== want.center_col || got.valid_res !== want.valid_res ||
              got.last !== want.last) begin
            mismatches++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("ERROR: expected value=%0d row=%0d col=%0d valid_res=%0b last=%0b",
                       want.value, want.center_row, want.center_col, want.valid_res,
                       want.last);
              $display("       actual   value=%0d row=%0d col=%0d valid_res=%0b last=%0b",
                       got.value, got.center_row, got.center_col, got.valid_res, got.last);
            end
          end
        end
      end
    end
    results_due <= predicted_centers.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for conv3x3_abs_saturate_core: drives pixels and register writes,
// varies the idling of both channels and gives the verdict.
// Depends on c3as_pkg, the block and conv3x3_result_checker.
module tb_top;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASE_CAP    = 160;
  localparam int BIG_ITEMS    = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int QUIET_LIMIT  = 20000;
  localparam logic [c3as_pkg::CFG_IDX_W-1:0] REG_UNMAPPED =
    c3as_pkg::REG_IMAGE_HEIGHT + 1'b1;

  typedef enum int {PIX_FULL, PIX_DARK, PIX_EXTREME} pixel_style_t;
  typedef enum int {COEF_RANDOM, COEF_SMALL, COEF_EXTREME} coef_style_t;

  typedef struct {
    c3as_pkg::coef_row_t           top;
    c3as_pkg::coef_row_t           mid;
    c3as_pkg::coef_row_t           bot;
    logic [c3as_pkg::WIDTH_W-1:0]  width;
    logic [c3as_pkg::HEIGHT_W-1:0] height;
  } conv_setup_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  c3as_pkg::pix_t                  in_pixel = '0;
  logic                            in_frame_start = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [c3as_pkg::PIX_W-1:0]      out_value;
  logic [c3as_pkg::ROW_OUT_W-1:0]  out_center_row;
  logic [c3as_pkg::COL_OUT_W-1:0]  out_center_col;
  logic                            out_valid_res;
  logic                            out_last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [c3as_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [c3as_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                              mismatches;
  int                              results_due;

  int send_idle_pct  = 10;
  int recv_idle_pct  = 64;
  int stall_requests = 0;
  int stalls_served  = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  initial forever #4 clk = ~clk;

  conv3x3_abs_saturate_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_center_row (out_center_row),
    .out_center_col (out_center_col),
    .out_valid_res  (out_valid_res),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  conv3x3_result_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) result_check (.*);

  // A stall request holds the result channel off for a long stretch; otherwise it idles
  // at random.
  always @(posedge clk) begin
    if (hold_left == 0 && stalls_served != stall_requests) begin
      hold_left = HOLD_CYCLES;
      stalls_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready) ||
                   (cfg_valid && cfg_ready))) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic c3as_pkg::pix_t pick_pixel(pixel_style_t style);
    case (style)
      PIX_DARK:    return c3as_pkg::pix_t'($urandom_range(7));
      PIX_EXTREME: return $urandom_range(1) ? '1 : '0;
      default:     return c3as_pkg::pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [c3as_pkg::COEF_W-1:0] pick_coeff(coef_style_t style);
    case (style)
      COEF_SMALL: return c3as_pkg::COEF_W'($urandom_range(4)) - c3as_pkg::COEF_W'(2);
      COEF_EXTREME: begin
        case ($urandom_range(3))
          0:       return 8'h7F;
          1:       return 8'h80;
          2:       return 8'h00;
          default: return 8'hFF;
        endcase
      end
      default: return c3as_pkg::COEF_W'($urandom());
    endcase
  endfunction

  function automatic c3as_pkg::coef_row_t pick_coeff_row(coef_style_t style);
    return {pick_coeff(style), pick_coeff(style), pick_coeff(style)};
  endfunction

  function automatic conv_setup_t random_setup();
    conv_setup_t s;
    coef_style_t style;
    int          pick;
    style = coef_style_t'($urandom_range(2));
    s.top = pick_coeff_row(style);
    s.mid = pick_coeff_row(style);
    s.bot = pick_coeff_row(style);
    // Mostly small images; now and then a value out of range, which means the maximum.
    pick = $urandom_range(99);
    if (pick < 75)      s.width = c3as_pkg::WIDTH_W'($urandom_range(1, 12));
    else if (pick < 90) s.width = c3as_pkg::WIDTH_W'($urandom_range(13, 48));
    else if (pick < 95) s.width = '0;
    else                s.width = c3as_pkg::WIDTH_W'($urandom_range(MAX_WIDTH + 1, 4095));
    pick = $urandom_range(99);
    if (pick < 75)      s.height = c3as_pkg::HEIGHT_W'($urandom_range(1, 8));
    else if (pick < 90) s.height = c3as_pkg::HEIGHT_W'($urandom_range(9, 24));
    else if (pick < 95) s.height = '0;
    else                s.height = c3as_pkg::HEIGHT_W'($urandom_range(MAX_HEIGHT + 1, 8191));
    return s;
  endfunction

  function automatic int frame_pixels(conv_setup_t s);
    int w;
    int h;
    w = (s.width == 0 || s.width > MAX_WIDTH) ? MAX_WIDTH : int'(s.width);
    h = (s.height == 0 || s.height > MAX_HEIGHT) ? MAX_HEIGHT : int'(s.height);
    return w * h;
  endfunction

  // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [c3as_pkg::CFG_IDX_W-1:0] idx,
                           input logic [c3as_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input conv_setup_t s, input bit add_unmapped);
    write_reg(c3as_pkg::REG_COEFF_TOP, s.top);
    write_reg(c3as_pkg::REG_COEFF_MID, s.mid);
    write_reg(c3as_pkg::REG_COEFF_BOT, s.bot);
    write_reg(c3as_pkg::REG_IMAGE_WIDTH,
              {(c3as_pkg::CFG_DATA_W - c3as_pkg::WIDTH_W)'($urandom()), s.width});
    write_reg(c3as_pkg::REG_IMAGE_HEIGHT,
              {(c3as_pkg::CFG_DATA_W - c3as_pkg::HEIGHT_W)'($urandom()), s.height});
    if (add_unmapped) begin
      write_reg(REG_UNMAPPED + c3as_pkg::CFG_IDX_W'($urandom_range(2)),
                c3as_pkg::CFG_DATA_W'($urandom()));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input c3as_pkg::pix_t px, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= px;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
  endtask

  // The extra edge lets the checker count the last pixel transfer before the wait.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
  endtask

  task automatic run_phase(input int n_items, input int frame_len, input bit fresh_start,
                           input bit mark_frames, input pixel_style_t style,
                           input int pause_at);
    for (int k = 0; k < n_items; k++) begin
      logic fs;
      if (k == pause_at) drain_results();
      if (k == 0) fs = fresh_start;
      else        fs = mark_frames && (k % frame_len == 0);
      // Now and then a frame restarts early.
      if ($urandom_range(99) < 2) fs = 1'b1;
      send_pixel(pick_pixel(style), fs);
    end
  endtask

  initial begin
    conv_setup_t    setup;
    c3as_pkg::pix_t probe_frame [12];
    int             random_sent;
    int             n_items;
    int             frame_len;
    probe_frame = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                    8'd0, 8'd255, 8'd0, 8'd128};
    random_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry and zero coefficients; these wait out the line store clearing.
    for (int k = 0; k < 4; k++) send_pixel(k[0] ? 8'd0 : 8'd255, k == 0);
    drain_results();

    // A 4x3 frame with extreme coefficients, then an overrun into the next frame
    // without a frame start, then a frame start in the middle of a line.
    setup = '{top: 24'h7F7F7F, mid: 24'h808080, bot: 24'h01FF00, width: 12'd4, height: 13'd3};
    load_config(setup, 1'b1);
    for (int k = 0; k < 12; k++) send_pixel(probe_frame[k], k == 0);
    for (int k = 0; k < 3; k++) send_pixel(~probe_frame[k], 1'b0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    drain_results();

    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 64;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      setup = random_setup();
      load_config(setup, $urandom_range(9) == 0);
      frame_len = frame_pixels(setup);
      n_items   = frame_len * $urandom_range(1, 3);
      if (n_items > PHASE_CAP) n_items = $urandom_range(20, PHASE_CAP);
      // A phase that starts without a frame start continues the old position.
      run_phase(n_items, frame_len, $urandom_range(9) != 0, $urandom_range(9) < 7,
                pixel_style_t'($urandom_range(2)), -1);
      random_sent += n_items;
      drain_results();
    end

    // Long hold-off on the results so the block backs up into its input, then a pause
    // in the middle of the frame until every result is out.
    setup = random_setup();
    setup.width  = 12'd10;
    setup.height = 13'd8;
    load_config(setup, 1'b0);
    stall_requests++;
    run_phase(80, 80, 1'b1, 1'b1, PIX_FULL, 40);
    drain_results();

    // Largest geometries: the start of a full-width frame, and of a full-height frame
    // at width three.
    setup = random_setup();
    setup.width  = c3as_pkg::WIDTH_W'(MAX_WIDTH);
    setup.height = 13'd2;
    load_config(setup, 1'b0);
    run_phase(BIG_ITEMS, 2 * MAX_WIDTH, 1'b1, 1'b1, PIX_DARK, -1);
    drain_results();

    setup = random_setup();
    setup.width  = 12'd3;
    setup.height = c3as_pkg::HEIGHT_W'(MAX_HEIGHT);
    load_config(setup, 1'b0);
    run_phase(BIG_ITEMS, 3 * MAX_HEIGHT, 1'b1, 1'b1, PIX_FULL, -1);
    drain_results();

    setup = random_setup();
    setup.width  = '1;
    setup.height = '1;
    load_config(setup, 1'b0);
    run_phase(40, MAX_WIDTH * MAX_HEIGHT, 1'b1, 1'b1, PIX_EXTREME, -1);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
